### hw/rtl/espt_pkg.sv
// ----------------------------------------------------------------------------
// espt_pkg: shared types and constants of the encoder speed/position tracker
// Register indexes, beat layouts, configuration and tracker state structs.
// ----------------------------------------------------------------------------
package espt_pkg;

  // counts per revolution, a power of two in 256 .. 65536
  localparam int unsigned COUNTS_PER_REV = 4096;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned RAW_W    = 16;
  localparam int unsigned DIFF_W   = 17;
  localparam int unsigned TOTAL_W  = 32;
  localparam int unsigned POS_W    = 12;
  localparam int unsigned SPEED_W  = 16;
  localparam int unsigned OFFSET_W = 13;
  localparam int unsigned SCALE_W  = 16;
  localparam int unsigned SHIFT_W  = 4;

  localparam int unsigned FRAC_BITS   = 3;
  localparam int unsigned MAX_SHIFT   = 8;
  localparam int unsigned SPEED_SHIFT = 12;  // speed divisor of 4096
  // average holds a 16-bit speed with 3 fractional bits
  localparam int unsigned ACC_W = SPEED_W + FRAC_BITS;

  localparam logic [OFFSET_W-1:0] OFFSET_RST = '0;
  localparam logic [SCALE_W-1:0]  SCALE_RST  = 16'd60000;
  localparam logic [SHIFT_W-1:0]  SHIFT_RST  = 4'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIRECTION_INVERT = 2'd0,
    CFG_POSITION_OFFSET  = 2'd1,
    CFG_SPEED_SCALE      = 2'd2,
    CFG_SMOOTHING_SHIFT  = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_CLEAR  = 1'b1
  } req_e;

  typedef struct packed {
    logic                       direction_invert;
    logic signed [OFFSET_W-1:0] position_offset;
    logic        [SCALE_W-1:0]  speed_scale;
    logic        [SHIFT_W-1:0]  smoothing_shift;
  } cfg_t;

  typedef struct packed {
    logic [RAW_W-1:0]          last_count;
    logic [TOTAL_W-1:0]        total_count;
    logic signed [ACC_W-1:0]   smooth_acc;
  } state_t;

  typedef struct packed {
    req_e             req_type;
    logic [RAW_W-1:0] raw_count;
  } in_beat_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0]  diff_ticks;
    logic signed [TOTAL_W-1:0] total_ticks;
    logic        [POS_W-1:0]   position;
    logic signed [SPEED_W-1:0] raw_speed;
    logic signed [SPEED_W-1:0] smooth_speed;
  } out_beat_t;

endpackage

### hw/rtl/espt_if.sv
// ----------------------------------------------------------------------------
// espt_in_if / espt_out_if: valid/ready channels of the tracker
// Sample/clear request channel and result channel.
// ----------------------------------------------------------------------------
interface espt_in_if;
  logic                      valid;
  logic                      ready;
  espt_pkg::req_e            req_type;
  logic [espt_pkg::RAW_W-1:0] raw_count;

  modport source (output valid, output req_type, output raw_count, input ready);
  modport sink   (input valid, input req_type, input raw_count, output ready);
endinterface

interface espt_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [espt_pkg::DIFF_W-1:0]  diff_ticks;
  logic signed [espt_pkg::TOTAL_W-1:0] total_ticks;
  logic        [espt_pkg::POS_W-1:0]   position;
  logic signed [espt_pkg::SPEED_W-1:0] raw_speed;
  logic signed [espt_pkg::SPEED_W-1:0] smooth_speed;

  modport source (output valid, output diff_ticks, output total_ticks,
                  output position, output raw_speed, output smooth_speed,
                  input ready);
  modport sink   (input valid, input diff_ticks, input total_ticks,
                  input position, input raw_speed, input smooth_speed,
                  output ready);
endinterface

### hw/rtl/espt_cfg_regs.sv
// ----------------------------------------------------------------------------
// espt_cfg_regs: configuration register file
// Write-only registers for direction, offset, speed scale and smoothing.
// ----------------------------------------------------------------------------
module espt_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [espt_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [espt_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output espt_pkg::cfg_t                    cfg_o
);

  espt_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (espt_pkg::cfg_idx_e'(cfg_idx_i))
        espt_pkg::CFG_DIRECTION_INVERT: cfg_d.direction_invert = cfg_wdata_i[0];
        espt_pkg::CFG_POSITION_OFFSET:
          cfg_d.position_offset = $signed(cfg_wdata_i[espt_pkg::OFFSET_W-1:0]);
        espt_pkg::CFG_SPEED_SCALE:
          cfg_d.speed_scale = cfg_wdata_i[espt_pkg::SCALE_W-1:0];
        espt_pkg::CFG_SMOOTHING_SHIFT:
          cfg_d.smoothing_shift = cfg_wdata_i[espt_pkg::SHIFT_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.direction_invert <= 1'b0;
      cfg_q.position_offset  <= espt_pkg::OFFSET_RST;
      cfg_q.speed_scale      <= espt_pkg::SCALE_RST;
      cfg_q.smoothing_shift  <= espt_pkg::SHIFT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hw/rtl/espt_datapath.sv
// ----------------------------------------------------------------------------
// espt_datapath: single-pass tracker arithmetic
// Wrap-aware difference, total, speed scaling, smoothing and position.
// ----------------------------------------------------------------------------
module espt_datapath #(
  parameter int unsigned COUNTS_PER_REV = espt_pkg::COUNTS_PER_REV
) (
  input  espt_pkg::cfg_t     cfg_i,
  input  espt_pkg::state_t   state_i,
  input  espt_pkg::in_beat_t beat_i,
  output espt_pkg::state_t   state_o,
  output espt_pkg::out_beat_t beat_o
);

  localparam int unsigned PROD_W = 2 * espt_pkg::DIFF_W;
  localparam int unsigned QUOT_W = PROD_W - espt_pkg::SPEED_SHIFT;
  localparam int unsigned SUM_W  = espt_pkg::ACC_W + espt_pkg::MAX_SHIFT + 1;
  localparam logic [espt_pkg::TOTAL_W-1:0] CPR_MASK =
    espt_pkg::TOTAL_W'(COUNTS_PER_REV - 1);
  localparam logic signed [QUOT_W-1:0] SAT_HI = QUOT_W'(32767);
  localparam logic signed [QUOT_W-1:0] SAT_LO = -(QUOT_W'(32768));

  logic                                is_clear;
  logic [espt_pkg::RAW_W-1:0]          fwd, bwd;
  logic signed [espt_pkg::DIFF_W-1:0]  d_near, d_dir, d;
  logic signed [espt_pkg::DIFF_W-1:0]  scale_s;
  logic signed [PROD_W-1:0]            prod, prod_adj;
  logic signed [QUOT_W-1:0]            quot;
  logic signed [espt_pkg::SPEED_W-1:0] speed_sat, speed;
  logic [espt_pkg::SHIFT_W-1:0]        k;
  logic signed [SUM_W-1:0]             acc_ext, speed_ext, sum, sum_sh;
  logic signed [espt_pkg::ACC_W-1:0]   acc_new, acc_out;
  logic [espt_pkg::TOTAL_W-1:0]        total_new, total_out, pos_full;

  assign is_clear = (beat_i.req_type == espt_pkg::REQ_CLEAR);

  // shorter of the two wrap distances, a tie goes forward
  assign fwd    = beat_i.raw_count - state_i.last_count;
  assign bwd    = state_i.last_count - beat_i.raw_count;
  assign d_near = (fwd > bwd) ? -$signed({1'b0, bwd}) : $signed({1'b0, fwd});
  assign d_dir  = cfg_i.direction_invert ? -d_near : d_near;
  assign d      = is_clear ? '0 : d_dir;

  // speed = d * scale / 4096, truncated toward zero, then saturated
  assign scale_s  = $signed({1'b0, cfg_i.speed_scale});
  assign prod     = d * scale_s;
  assign prod_adj = prod + (prod[PROD_W-1] ? PROD_W'(4095) : PROD_W'(0));
  assign quot     = prod_adj[PROD_W-1:espt_pkg::SPEED_SHIFT];

  always_comb begin
    if (quot > SAT_HI) begin
      speed_sat = espt_pkg::SPEED_W'(SAT_HI);
    end else if (quot < SAT_LO) begin
      speed_sat = espt_pkg::SPEED_W'(SAT_LO);
    end else begin
      speed_sat = quot[espt_pkg::SPEED_W-1:0];
    end
  end

  assign speed = is_clear ? '0 : speed_sat;

  // acc = floor((acc * (2^k - 1) + speed * 8) / 2^k)
  assign k = (cfg_i.smoothing_shift > espt_pkg::SHIFT_W'(espt_pkg::MAX_SHIFT))
             ? espt_pkg::SHIFT_W'(espt_pkg::MAX_SHIFT) : cfg_i.smoothing_shift;
  assign acc_ext   = {{(SUM_W-espt_pkg::ACC_W){state_i.smooth_acc[espt_pkg::ACC_W-1]}},
                      state_i.smooth_acc};
  assign speed_ext = {{(SUM_W-espt_pkg::ACC_W){speed_sat[espt_pkg::SPEED_W-1]}},
                      speed_sat, {espt_pkg::FRAC_BITS{1'b0}}};
  assign sum       = (acc_ext <<< k) - acc_ext + speed_ext;
  assign sum_sh    = sum >>> k;
  assign acc_new   = sum_sh[espt_pkg::ACC_W-1:0];
  assign acc_out   = is_clear ? state_i.smooth_acc : acc_new;

  assign total_new = is_clear ? '0
                   : state_i.total_count
                     + {{(espt_pkg::TOTAL_W-espt_pkg::DIFF_W){d[espt_pkg::DIFF_W-1]}}, d};
  assign total_out = total_new
                   + {{(espt_pkg::TOTAL_W-espt_pkg::OFFSET_W)
                       {cfg_i.position_offset[espt_pkg::OFFSET_W-1]}},
                      cfg_i.position_offset};
  // power-of-two revolution: the mask gives the euclidean remainder
  assign pos_full  = total_out & CPR_MASK;

  assign state_o.last_count  = is_clear ? state_i.last_count : beat_i.raw_count;
  assign state_o.total_count = total_new;
  assign state_o.smooth_acc  = acc_out;

  assign beat_o.diff_ticks   = d;
  assign beat_o.total_ticks  = $signed(total_out);
  assign beat_o.position     = pos_full[espt_pkg::POS_W-1:0];
  assign beat_o.raw_speed    = speed;
  assign beat_o.smooth_speed = acc_out[espt_pkg::ACC_W-1:espt_pkg::FRAC_BITS];

endmodule

### hw/rtl/encoder_speed_position_tracker_unit.sv
// ----------------------------------------------------------------------------
// encoder_speed_position_tracker_unit: encoder speed and position tracker
// Path: an accepted request beat enters the input register, its result the
//   result register. Throughput: one beat per cycle unless the result side
//   stalls; the path is the one 17x17 multiply of the speed scaling between them.
// Reset: tracker state, valids and configuration clear asynchronously on
//   rst_ni; configuration returns to scale 60000, shift 3, others zero.
// ----------------------------------------------------------------------------
module encoder_speed_position_tracker_unit #(
  parameter int unsigned COUNTS_PER_REV = espt_pkg::COUNTS_PER_REV
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [espt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [espt_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // request and result channels
  espt_in_if.sink                         in_i,
  espt_out_if.source                      out_o
);

  espt_pkg::cfg_t      cfg;
  espt_pkg::state_t    state_q, state_d;
  espt_pkg::in_beat_t  in_beat_q;
  espt_pkg::out_beat_t res_beat, out_beat_q;
  logic                in_vld_q;
  logic                out_vld_q;
  logic                advance;

  espt_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // the whole step is one combinational pass from the input register
  espt_datapath #(
    .COUNTS_PER_REV (COUNTS_PER_REV)
  ) u_datapath (
    .cfg_i   (cfg),
    .state_i (state_q),
    .beat_i  (in_beat_q),
    .state_o (state_d),
    .beat_o  (res_beat)
  );

  // the input register moves on when it is empty or the result register is empty or drains
  assign advance  = !out_vld_q || out_o.ready;
  assign in_i.ready = !in_vld_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_beat_q.req_type  <= in_i.req_type;
      in_beat_q.raw_count <= in_i.raw_count;
    end
  end

  // result register and tracker state commit together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      state_q   <= '0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
      if (in_vld_q) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_vld_q) begin
      out_beat_q <= res_beat;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.diff_ticks   = out_beat_q.diff_ticks;
  assign out_o.total_ticks  = out_beat_q.total_ticks;
  assign out_o.position     = out_beat_q.position;
  assign out_o.raw_speed    = out_beat_q.raw_speed;
  assign out_o.smooth_speed = out_beat_q.smooth_speed;

endmodule

### dv/espt_checker.sv
// ----------------------------------------------------------------------------
// espt_checker: result checker of the encoder speed/position tracker
// Follows the register writes, predicts one result per accepted request
// beat and compares every result beat field by field in arrival order.
// ----------------------------------------------------------------------------
module espt_checker import espt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  espt_in_if                    in_mon,
  espt_out_if                   out_mon,
  output int unsigned           fail_cnt,
  output int unsigned           pend_cnt,
  output int unsigned           beat_cnt
);
  timeunit 1ns;
  timeprecision 1ps;

  // predictor copy of the registers
  logic                       dir_inv;
  logic signed [OFFSET_W-1:0] pos_offs;
  logic [SCALE_W-1:0]         rpm_scale;
  logic [SHIFT_W-1:0]         avg_shift;

  // predictor copy of the tracker state
  logic [RAW_W-1:0]   prev_raw;
  logic [TOTAL_W-1:0] run_total;
  longint             avg_acc;

  out_beat_t want_q[$];

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  task automatic report(string msg);
    fail_cnt++;
    if (fail_cnt <= 30) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(string fld, logic [TOTAL_W-1:0] got, logic [TOTAL_W-1:0] want);
    if (got !== want) report($sformatf("%s got %0h want %0h", fld, got, want));
  endtask

  task automatic track_beat(req_e req, logic [RAW_W-1:0] raw);
    logic [RAW_W-1:0]   fwd;
    logic [RAW_W-1:0]   bwd;
    logic [TOTAL_W-1:0] tot;
    longint             d;
    longint             spd;
    longint             sm;
    int unsigned        k;
    out_beat_t          e;
    d   = 0;
    spd = 0;
    if (req == REQ_SAMPLE) begin
      fwd = raw - prev_raw;
      bwd = prev_raw - raw;
      // shorter way round wins, a tie counts forward
      d = (fwd > bwd) ? -longint'(bwd) : longint'(fwd);
      if (dir_inv) d = -d;
      run_total = run_total + d[TOTAL_W-1:0];
      prev_raw  = raw;
      spd = clip16((d * longint'(rpm_scale)) / (longint'(1) << SPEED_SHIFT));
      k = (avg_shift > MAX_SHIFT) ? MAX_SHIFT : avg_shift;
      // arithmetic shift gives floor rounding
      avg_acc = (avg_acc * ((longint'(1) << k) - 1) + spd * (longint'(1) << FRAC_BITS)) >>> k;
    end else begin
      run_total = '0;
    end
    tot = run_total + {{(TOTAL_W-OFFSET_W){pos_offs[OFFSET_W-1]}}, pos_offs};
    sm  = clip16(avg_acc >>> FRAC_BITS);
    e.diff_ticks   = d[DIFF_W-1:0];
    e.total_ticks  = tot;
    // power-of-two modulus: low bits are the euclidean remainder
    e.position     = POS_W'(tot & (COUNTS_PER_REV - 1));
    e.raw_speed    = spd[SPEED_W-1:0];
    e.smooth_speed = sm[SPEED_W-1:0];
    want_q.push_back(e);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_inv   = 1'b0;
      pos_offs  = OFFSET_RST;
      rpm_scale = SCALE_RST;
      avg_shift = SHIFT_RST;
      prev_raw  = '0;
      run_total = '0;
      avg_acc   = 0;
      want_q.delete();
      pend_cnt  = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        beat_cnt++;
        if (want_q.size() == 0) begin
          report("result beat with no request outstanding");
        end else begin
          out_beat_t w;
          w = want_q.pop_front();
          check_field("diff_ticks", TOTAL_W'(out_mon.diff_ticks), TOTAL_W'(w.diff_ticks));
          check_field("total_ticks", out_mon.total_ticks, w.total_ticks);
          check_field("position", TOTAL_W'(out_mon.position), TOTAL_W'(w.position));
          check_field("raw_speed", TOTAL_W'(out_mon.raw_speed), TOTAL_W'(w.raw_speed));
          check_field("smooth_speed", TOTAL_W'(out_mon.smooth_speed),
                      TOTAL_W'(w.smooth_speed));
        end
      end
      if (in_mon.valid && in_mon.ready) track_beat(in_mon.req_type, in_mon.raw_count);
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_DIRECTION_INVERT: dir_inv   = cfg_wdata_i[0];
          CFG_POSITION_OFFSET:  pos_offs  = cfg_wdata_i[OFFSET_W-1:0];
          CFG_SPEED_SCALE:      rpm_scale = cfg_wdata_i[SCALE_W-1:0];
          CFG_SMOOTHING_SHIFT:  avg_shift = cfg_wdata_i[SHIFT_W-1:0];
          default: ;
        endcase
      end
      pend_cnt = want_q.size();
    end
  end

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the encoder speed/position tracker
// Drives request beats and register writes, stalls the result side at
// random and gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import espt_pkg::*;

  // far above the slowest legal run, drains included
  localparam int unsigned CYCLE_LIMIT = 200_000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  espt_in_if  in_if ();
  espt_out_if out_if ();

  int unsigned fail_cnt;
  int unsigned pend_cnt;
  int unsigned beat_cnt;

  // stimulus bookkeeping
  logic [RAW_W-1:0]   last_raw;    // last sample sent, used to shape motion
  logic signed [15:0] vel;         // current simulated velocity in ticks/sample
  bit                 in_idle;     // sender gaps enabled
  bit                 out_idle;    // receiver stalls enabled
  int unsigned        stall_left;
  int unsigned        stall_draw;
  int unsigned        cycle_cnt;
  int unsigned        clear_cnt;
  int unsigned        cfg_sets;

  encoder_speed_position_tracker_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  espt_checker i_track_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_mon      (in_if),
    .out_mon     (out_if),
    .fail_cnt    (fail_cnt),
    .pend_cnt    (pend_cnt),
    .beat_cnt    (beat_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("run timed out after %0d cycles, %0d results outstanding", cycle_cnt, pend_cnt);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: after a beat, may drop ready at random while stalls are enabled
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left   <= 1;
      out_idle     <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      if (stall_left == 1) out_if.ready <= 1'b1;
    end else if (out_if.valid && out_if.ready) begin
      stall_draw = out_idle ? $urandom_range(4, 0) : 0;
      if (stall_draw != 0) begin
        out_if.ready <= 1'b0;
        stall_left   <= stall_draw;
      end
      // switch between stalling and free-running stretches now and then
      if ($urandom_range(39, 0) == 0) out_idle <= ~out_idle;
    end
  end

  // one request beat, preceded by a random gap while sender gaps are enabled
  task automatic send_beat(req_e req, logic [RAW_W-1:0] raw);
    int unsigned gap;
    gap = in_idle ? $urandom_range(4, 0) : 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.req_type  <= req;
    in_if.raw_count <= raw;
    do @(posedge clk_i); while (!in_if.ready);
    if (req == REQ_SAMPLE) last_raw = raw;
    else clear_cnt++;
  endtask

  // stop sending and wait for every outstanding result, then a short settle
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    while (pend_cnt != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  // full register set; only called with the tracker idle
  task automatic set_config(bit inv, logic signed [OFFSET_W-1:0] offs,
                            logic [SCALE_W-1:0] scale, logic [SHIFT_W-1:0] shift);
    cfg_write(CFG_DIRECTION_INVERT, CFG_DATA_W'(inv));
    cfg_write(CFG_POSITION_OFFSET, {{(CFG_DATA_W-OFFSET_W){offs[OFFSET_W-1]}}, offs});
    cfg_write(CFG_SPEED_SCALE, scale);
    cfg_write(CFG_SMOOTHING_SHIFT, CFG_DATA_W'(shift));
    cfg_we_i <= 1'b0;
    cfg_sets++;
  endtask

  // mostly steady motion with jitter, plus fast moves, ties, stops,
  // clears and arbitrary jumps
  task automatic run_random(int unsigned n_items);
    int unsigned sel;
    logic [RAW_W-1:0] raw;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i % 64 == 0) in_idle = ($urandom_range(3, 0) != 0);
      if (i % 32 == 0) vel = 16'($urandom_range(4000, 0)) - 16'sd2000;
      // occasional full drain in the middle of traffic
      if ($urandom_range(249, 0) == 0) wait_idle();
      sel = $urandom_range(99, 0);
      if (sel < 8) begin
        send_beat(REQ_CLEAR, 16'($urandom()));
      end else begin
        if (sel < 60)      raw = last_raw + vel + 16'($urandom_range(16, 0)) - 16'd8;
        else if (sel < 72) raw = last_raw + 16'($urandom_range(16000, 0)) - 16'd8000;
        else if (sel < 80) raw = last_raw + 16'h8000 + 16'($urandom_range(2, 0)) - 16'd1;
        else if (sel < 85) raw = last_raw;
        else               raw = 16'($urandom());
        send_beat(REQ_SAMPLE, raw);
      end
    end
  endtask

  initial begin
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= CFG_DIRECTION_INVERT;
    cfg_wdata_i     <= '0;
    in_if.valid     <= 1'b0;
    in_if.req_type  <= REQ_SAMPLE;
    in_if.raw_count <= '0;
    last_raw        = '0;
    vel             = '0;
    in_idle         = 1'b1;
    clear_cnt       = 0;
    cfg_sets        = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset register values: extremes of the counter difference
    send_beat(REQ_SAMPLE, 16'h0000);   // no motion
    send_beat(REQ_SAMPLE, 16'h0001);
    send_beat(REQ_SAMPLE, 16'h7FFF);   // large forward step, speed saturates
    send_beat(REQ_SAMPLE, 16'hFFFF);   // tie, counts forward
    send_beat(REQ_SAMPLE, 16'h7FFF);   // tie across the wrap
    send_beat(REQ_SAMPLE, 16'h0000);   // largest backward step
    send_beat(REQ_SAMPLE, 16'hFFFF);   // -1 tick, speed truncates toward zero
    send_beat(REQ_SAMPLE, 16'h0001);   // forward across the wrap
    send_beat(REQ_CLEAR,  16'hA5A5);
    send_beat(REQ_SAMPLE, 16'h0000);   // total goes negative, position wraps
    send_beat(REQ_SAMPLE, 16'h8001);
    send_beat(REQ_SAMPLE, 16'h0002);
    send_beat(REQ_SAMPLE, 16'h8003);
    send_beat(REQ_CLEAR,  16'hFFFF);   // clear keeps last count and average
    send_beat(REQ_SAMPLE, 16'h8003);
    run_random(350);

    // inverted, most negative offset, top scale, average takes new speed directly
    wait_idle();
    set_config(1'b1, -13'sd4096, 16'hFFFF, 4'd0);
    send_beat(REQ_CLEAR,  16'h0000);   // reports the offset alone
    send_beat(REQ_SAMPLE, last_raw + 16'h8000);   // tie, inverted to -32768
    send_beat(REQ_SAMPLE, last_raw + 16'h7FFF);
    send_beat(REQ_SAMPLE, last_raw - 16'h7FFF);
    run_random(300);

    // most positive offset, smallest nonzero scale, heaviest smoothing
    wait_idle();
    set_config(1'b0, 13'sd4095, 16'd1, 4'd8);
    send_beat(REQ_SAMPLE, last_raw + 16'h7FFF);
    send_beat(REQ_SAMPLE, last_raw - 16'h7FFF);
    run_random(300);

    // zero scale and a shift above the limit
    wait_idle();
    set_config(1'b1, 13'($urandom()), 16'd0, 4'd15);
    run_random(150);

    // fully random register settings
    repeat (4) begin
      wait_idle();
      set_config(1'($urandom()), 13'($urandom()), 16'($urandom()),
                 4'($urandom_range(15, 0)));
      run_random(110);
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    $display("checked %0d result beats, %0d of them clears", beat_cnt, clear_cnt);
    $display("register settings written: %0d after the reset values", cfg_sets);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
